// ===== rtl/tsa_pkg.sv =====
package tsa_pkg;

  localparam int unsigned AddrW   = 32;
  localparam int unsigned OwnerW  = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [AddrW-1:0] SysBytes = 32'h0000_0030;

  localparam logic [StatusW-1:0] StFound       = 3'd0;
  localparam logic [StatusW-1:0] StAllocated   = 3'd1;
  localparam logic [StatusW-1:0] StFull        = 3'd2;
  localparam logic [StatusW-1:0] StFreed       = 3'd3;
  localparam logic [StatusW-1:0] StFreeFailed  = 3'd4;

  localparam logic [CfgIdxW-1:0] RegAreaBase     = 8'd0;
  localparam logic [CfgIdxW-1:0] RegUserAreaSize = 8'd1;

  localparam logic ActGet  = 1'b0;
  localparam logic ActFree = 1'b1;

  typedef enum logic [4:0] {
    StateIdle   = 5'b00001,
    StateScan   = 5'b00010,
    StateDecide = 5'b00100,
    StateAdd    = 5'b01000,
    StateDone   = 5'b10000
  } state_e;

  typedef struct packed {
    logic                en;
    logic                keep;
    logic [OwnerW-1:0]   owner;
  } wr_ctrl_t;

endpackage

// ===== rtl/tsa_owner_mem.sv =====
module tsa_owner_mem #(
  parameter int unsigned Depth = 128,
  parameter int unsigned IdxW  = 7
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [IdxW-1:0]             rd_idx_i,
  output logic [tsa_pkg::OwnerW-1:0]  rd_owner_o,
  input  tsa_pkg::wr_ctrl_t           wr_ctrl_i,
  input  logic [IdxW-1:0]             wr_idx_i
);

  logic [tsa_pkg::OwnerW-1:0] mem [Depth];
  logic [Depth-1:0]           valid_q;
  logic [tsa_pkg::OwnerW-1:0] rdata_q;
  logic                       rvalid_q;

  always_ff @(posedge clk_i) begin
    if (wr_ctrl_i.en) begin
      mem[wr_idx_i] <= wr_ctrl_i.owner;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (wr_ctrl_i.en) begin
        valid_q[wr_idx_i] <= wr_ctrl_i.keep;
      end
      if (rd_en_i) begin
        rvalid_q <= valid_q[rd_idx_i];
      end
    end
  end

  assign rd_owner_o = rvalid_q ? rdata_q : '0;

endmodule

// ===== rtl/tls_slot_allocator.sv =====
// Thread-local storage slot allocator. A word on the slave side carries a
// thread id in tdata and the action in tuser (0 get or allocate, 1 free).
// The block scans its owner table through a single memory read port, one
// slot per cycle, looking for the lowest slot owned by the id and the lowest
// free slot in the same pass. After the scan, the Decide and Add states
// build the result; no new word is taken until the result is consumed. The
// slot address is area_base + index * (user_area_size + 0x30) + 0x30,
// modulo 2^32; it is zero for id 0 and for full or free results. Registers
// must be written by the user only while no request is in flight; the block does not enforce it.
module tls_slot_allocator #(
  parameter int unsigned SLOT_COUNT = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Bits from the lowest: thread_id[31:0].
  input  logic [31:0] s_axis_tdata,
  // Bits from the lowest: action[0].
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Bits from the lowest: slot_address[31:0], status[34:32], zero[39:35].
  output logic [39:0] m_axis_tdata
);

  localparam int unsigned IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CntW = $clog2(SLOT_COUNT + 1);

  tsa_pkg::state_e state_q, state_d;

  logic [31:0]         area_base_q;
  logic [31:0]         user_bytes_q;
  logic                action_q;
  logic [31:0]         tid_q;
  logic [CntW-1:0]     cnt_q;
  logic                cmp_vld_q;
  logic [IdxW-1:0]     cmp_idx_q;
  logic                have_match_q;
  logic                have_free_q;
  logic [IdxW-1:0]     match_idx_q;
  logic [IdxW-1:0]     free_idx_q;
  logic [31:0]         prod_q;
  logic                use_addr_q;
  logic [2:0]          status_q;
  logic [31:0]         out_addr_q;

  logic                rd_en;
  logic [31:0]         rd_owner;
  logic                hit;
  logic                empty;
  logic                last_read;
  tsa_pkg::wr_ctrl_t   wr_ctrl;
  logic [IdxW-1:0]     wr_idx;
  logic [IdxW-1:0]     sel_idx;
  logic [31:0]         stride;
  logic                sel_use;
  logic [2:0]          sel_status;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == tsa_pkg::StateIdle);
  assign m_axis_tvalid = (state_q == tsa_pkg::StateDone);
  assign m_axis_tdata  = {5'b0, status_q, out_addr_q};

  assign last_read = (cnt_q == CntW'(SLOT_COUNT));
  assign rd_en     = (state_q == tsa_pkg::StateScan) && !last_read;
  assign hit       = (rd_owner == tid_q);
  assign empty     = (rd_owner == '0);
  assign stride    = user_bytes_q + tsa_pkg::SysBytes;

  tsa_owner_mem #(
    .Depth (SLOT_COUNT),
    .IdxW  (IdxW)
  ) u_owner_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_idx_i   (cnt_q[IdxW-1:0]),
    .rd_owner_o (rd_owner),
    .wr_ctrl_i  (wr_ctrl),
    .wr_idx_i   (wr_idx)
  );

  always_comb begin
    sel_idx    = match_idx_q;
    sel_use    = 1'b0;
    sel_status = tsa_pkg::StFound;
    wr_ctrl    = '{en: 1'b0, keep: 1'b0, owner: tid_q};
    wr_idx     = match_idx_q;
    if (action_q == tsa_pkg::ActGet) begin
      if (tid_q == '0) begin
        sel_status = tsa_pkg::StFound;
      end else if (have_match_q) begin
        sel_use    = 1'b1;
        sel_status = tsa_pkg::StFound;
      end else if (have_free_q) begin
        sel_idx    = free_idx_q;
        sel_use    = 1'b1;
        sel_status = tsa_pkg::StAllocated;
        wr_ctrl.en   = (state_q == tsa_pkg::StateDecide);
        wr_ctrl.keep = 1'b1;
        wr_idx       = free_idx_q;
      end else begin
        sel_status = tsa_pkg::StFull;
      end
    end else begin
      if (have_match_q) begin
        sel_status = tsa_pkg::StFreed;
        wr_ctrl.en = (state_q == tsa_pkg::StateDecide);
      end else begin
        sel_status = tsa_pkg::StFreeFailed;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tsa_pkg::StateIdle: begin
        if (s_axis_tvalid) begin
          state_d = tsa_pkg::StateScan;
        end
      end
      tsa_pkg::StateScan: begin
        if (last_read) begin
          state_d = tsa_pkg::StateDecide;
        end
      end
      tsa_pkg::StateDecide: begin
        state_d = tsa_pkg::StateAdd;
      end
      tsa_pkg::StateAdd: begin
        state_d = tsa_pkg::StateDone;
      end
      tsa_pkg::StateDone: begin
        if (m_axis_tready) begin
          state_d = tsa_pkg::StateIdle;
        end
      end
      default: begin
        state_d = tsa_pkg::StateIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tsa_pkg::StateIdle;
      area_base_q  <= '0;
      user_bytes_q <= '0;
      cnt_q        <= '0;
      cmp_vld_q    <= 1'b0;
      have_match_q <= 1'b0;
      have_free_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == tsa_pkg::RegAreaBase) begin
          area_base_q <= cfg_data_i;
        end else if (cfg_index_i == tsa_pkg::RegUserAreaSize) begin
          user_bytes_q <= cfg_data_i;
        end
      end
      cmp_vld_q <= rd_en;
      if (s_axis_tvalid && s_axis_tready) begin
        cnt_q        <= '0;
        have_match_q <= 1'b0;
        have_free_q  <= 1'b0;
      end else begin
        if (rd_en) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (cmp_vld_q) begin
          if (!have_match_q && hit) begin
            have_match_q <= 1'b1;
          end
          if (!have_free_q && empty) begin
            have_free_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      action_q <= s_axis_tuser;
      tid_q    <= s_axis_tdata;
    end
    cmp_idx_q <= cnt_q[IdxW-1:0];
    if (cmp_vld_q) begin
      if (!have_match_q && hit) begin
        match_idx_q <= cmp_idx_q;
      end
      if (!have_free_q && empty) begin
        free_idx_q <= cmp_idx_q;
      end
    end
    if (state_q == tsa_pkg::StateDecide) begin
      prod_q     <= 32'({{(32 - IdxW){1'b0}}, sel_idx} * stride);
      use_addr_q <= sel_use;
      status_q   <= sel_status;
    end
    if (state_q == tsa_pkg::StateAdd) begin
      out_addr_q <= use_addr_q ? (area_base_q + prod_q + tsa_pkg::SysBytes) : '0;
    end
  end

endmodule
